// ----- design/nbf_pkg.sv -----
`timescale 1ns / 1ps
package nbf_pkg;

  localparam int IDX_W     = 6;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRAV  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SOFT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_XLIM  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_YLIM  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ZLIM  = 3'd6;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_STEP = 1'b1;

  typedef struct packed {
    logic [6:0]  count;
    logic [31:0] grav;
    logic [31:0] eps;
    logic [31:0] dt;
    logic [30:0] xlim;
    logic [30:0] ylim;
    logic [30:0] zlim;
  } cfg_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_RD,
    OP_CAP_I,
    OP_CAP_P,
    OP_SQ,
    OP_SQRT,
    OP_CUBE,
    OP_GM,
    OP_NUM,
    OP_DIV,
    OP_CON,
    OP_VFAC,
    OP_DP,
    OP_DV,
    OP_EMIT,
    OP_CP_WR
  } dp_op_t;

  typedef struct packed {
    dp_op_t           op;
    logic [1:0]       axis;
    logic [IDX_W-1:0] addr;
    logic             last;
  } dp_cmd_t;

  typedef struct packed {
    logic done;
    logic out_free;
  } dp_stat_t;

endpackage

// ----- design/nbf_in_if.sv -----
`timescale 1ns / 1ps
interface nbf_in_if;
  logic               valid;
  logic               ready;
  logic               cmd;
  logic signed [31:0] in_pos_x;
  logic signed [31:0] in_pos_y;
  logic signed [31:0] in_pos_z;
  logic signed [31:0] in_vel_x;
  logic signed [31:0] in_vel_y;
  logic signed [31:0] in_vel_z;
  logic [31:0]        in_mass;

  modport source (output valid, cmd, in_pos_x, in_pos_y, in_pos_z, in_vel_x, in_vel_y,
                  in_vel_z, in_mass, input ready);
  modport sink (input valid, cmd, in_pos_x, in_pos_y, in_pos_z, in_vel_x, in_vel_y,
                in_vel_z, in_mass, output ready);
endinterface

// ----- design/nbf_out_if.sv -----
`timescale 1ns / 1ps
interface nbf_out_if;
  logic               valid;
  logic               ready;
  logic [5:0]         particle_index;
  logic signed [31:0] out_pos_x;
  logic signed [31:0] out_pos_y;
  logic signed [31:0] out_pos_z;
  logic signed [31:0] out_vel_x;
  logic signed [31:0] out_vel_y;
  logic signed [31:0] out_vel_z;
  logic               last_particle;

  modport source (output valid, particle_index, out_pos_x, out_pos_y, out_pos_z, out_vel_x,
                  out_vel_y, out_vel_z, last_particle, input ready);
  modport sink (input valid, particle_index, out_pos_x, out_pos_y, out_pos_z, out_vel_x,
                out_vel_y, out_vel_z, last_particle, output ready);
endinterface

// ----- design/nbf_cfg_if.sv -----
`timescale 1ns / 1ps
interface nbf_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- design/nbf_mul.sv -----
`timescale 1ns / 1ps
module nbf_mul (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [63:0]  a,
  input  logic [63:0]  b,
  output logic         done,
  output logic [127:0] prod
);

  logic [63:0] a_r, b_r;
  logic [2:0]  cnt;
  logic        busy;
  logic [63:0] pp;
  logic [6:0]  pp_sh;
  logic        pp_vld;
  logic [31:0] ah, bh;

  assign ah = cnt[1] ? a_r[63:32] : a_r[31:0];
  assign bh = cnt[0] ? b_r[63:32] : b_r[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      done   <= 1'b0;
      pp_vld <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        a_r    <= a;
        b_r    <= b;
        busy   <= 1'b1;
        cnt    <= '0;
        prod   <= '0;
        pp_vld <= 1'b0;
      end else if (busy) begin
        pp_vld <= (cnt < 3'd4);
        if (cnt < 3'd4) begin
          pp    <= ah * bh;
          pp_sh <= {cnt[1] & cnt[0], cnt[1] ^ cnt[0], 5'b0};
          cnt   <= cnt + 3'd1;
        end
        if (pp_vld) begin
          prod <= prod + ({64'b0, pp} << pp_sh);
        end
        if (cnt == 3'd4) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- design/nbf_div.sv -----
`timescale 1ns / 1ps
module nbf_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] num,
  input  logic [63:0] den,
  output logic        done,
  output logic [63:0] quot
);

  logic [63:0] rem, d;
  logic [5:0]  cnt;
  logic        busy;
  logic [64:0] trial;
  logic        ge;

  assign trial = {rem, quot[63]};
  assign ge    = (trial >= {1'b0, d});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        quot <= num;
        d    <= den;
        rem  <= '0;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        rem  <= ge ? 64'(trial - {1'b0, d}) : trial[63:0];
        quot <= {quot[62:0], ge};
        cnt  <= cnt + 6'd1;
        if (cnt == 6'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- design/nbf_ctrl.sv -----
`timescale 1ns / 1ps
module nbf_ctrl import nbf_pkg::*; #(
  parameter int MAX_PARTICLES = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_cmd,
  output logic       in_ready,
  input  logic [6:0] count,
  input  dp_stat_t   stat,
  output dp_cmd_t    cmd
);

  localparam int NW = $clog2(MAX_PARTICLES + 1);
  localparam logic [1:0] AX_LAST = 2'd2;

  typedef enum logic [4:0] {
    S_IDLE, S_I_RD, S_I_CAP, S_GM, S_P_CHK, S_P_RD, S_P_CAP, S_SQ, S_SQRT, S_CUBE,
    S_NUM, S_DIV, S_CON, S_VFAC, S_DP, S_DV, S_EMIT, S_CP_RD, S_CP_WR, S_WAIT
  } state_t;

  state_t        state, ret;
  logic [NW-1:0] n, i, p;
  logic [1:0]    k;
  logic [NW-1:0] n_eff;
  logic          i_last;

  assign n_eff    = (count > 7'(MAX_PARTICLES)) ? NW'(MAX_PARTICLES) : NW'(count);
  assign i_last   = (NW'(i + 1'b1) == n);
  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd.op   = OP_NONE;
    cmd.axis = k;
    cmd.addr = IDX_W'(i);
    cmd.last = i_last;
    unique case (state)
      S_IDLE:  if (in_valid && in_cmd == CMD_LOAD) cmd.op = OP_LOAD;
      S_I_RD:  cmd.op = OP_RD;
      S_I_CAP: cmd.op = OP_CAP_I;
      S_GM:    cmd.op = OP_GM;
      S_P_CHK: cmd.op = OP_NONE;
      S_P_RD: begin
        cmd.op   = OP_RD;
        cmd.addr = IDX_W'(p);
      end
      S_P_CAP: begin
        cmd.op   = OP_CAP_P;
        cmd.addr = IDX_W'(p);
      end
      S_SQ:    cmd.op = OP_SQ;
      S_SQRT:  cmd.op = OP_SQRT;
      S_CUBE:  cmd.op = OP_CUBE;
      S_NUM:   cmd.op = OP_NUM;
      S_DIV:   cmd.op = OP_DIV;
      S_CON:   cmd.op = OP_CON;
      S_VFAC:  cmd.op = OP_VFAC;
      S_DP:    cmd.op = OP_DP;
      S_DV:    cmd.op = OP_DV;
      S_EMIT:  if (stat.out_free) cmd.op = OP_EMIT;
      S_CP_RD: begin
        cmd.op   = OP_RD;
        cmd.addr = IDX_W'(p);
      end
      S_CP_WR: begin
        cmd.op   = OP_CP_WR;
        cmd.addr = IDX_W'(p);
      end
      S_WAIT:  cmd.op = OP_NONE;
      default: cmd.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ret   <= S_IDLE;
      n     <= '0;
      i     <= '0;
      p     <= '0;
      k     <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid && in_cmd == CMD_STEP) begin
            n <= n_eff;
            i <= '0;
            if (n_eff != '0) state <= S_I_RD;
          end
        end
        S_I_RD:  state <= S_I_CAP;
        S_I_CAP: state <= S_GM;
        S_GM: begin
          p     <= '0;
          ret   <= S_P_CHK;
          state <= S_WAIT;
        end
        S_P_CHK: begin
          if (p == n) begin
            k     <= '0;
            state <= S_VFAC;
          end else if (p == i) begin
            p <= p + 1'b1;
          end else begin
            state <= S_P_RD;
          end
        end
        S_P_RD: state <= S_P_CAP;
        S_P_CAP: begin
          k     <= '0;
          state <= S_SQ;
        end
        S_SQ: begin
          k     <= (k == AX_LAST) ? 2'd0 : k + 2'd1;
          ret   <= (k == AX_LAST) ? S_SQRT : S_SQ;
          state <= S_WAIT;
        end
        S_SQRT: begin
          ret   <= S_CUBE;
          state <= S_WAIT;
        end
        S_CUBE: begin
          ret   <= S_NUM;
          state <= S_WAIT;
        end
        S_NUM: begin
          ret   <= S_DIV;
          state <= S_WAIT;
        end
        S_DIV: begin
          ret   <= S_CON;
          state <= S_WAIT;
        end
        S_CON: begin
          k     <= (k == AX_LAST) ? 2'd0 : k + 2'd1;
          ret   <= (k == AX_LAST) ? S_P_CHK : S_CON;
          if (k == AX_LAST) p <= p + 1'b1;
          state <= S_WAIT;
        end
        S_VFAC: begin
          ret   <= S_DP;
          state <= S_WAIT;
        end
        S_DP: begin
          k     <= (k == AX_LAST) ? 2'd0 : k + 2'd1;
          ret   <= (k == AX_LAST) ? S_DV : S_DP;
          state <= S_WAIT;
        end
        S_DV: begin
          k     <= (k == AX_LAST) ? 2'd0 : k + 2'd1;
          ret   <= (k == AX_LAST) ? S_EMIT : S_DV;
          state <= S_WAIT;
        end
        S_EMIT: begin
          if (stat.out_free) begin
            i <= i + 1'b1;
            if (i_last) begin
              p     <= '0;
              state <= S_CP_RD;
            end else begin
              state <= S_I_RD;
            end
          end
        end
        S_CP_RD: state <= S_CP_WR;
        S_CP_WR: begin
          p     <= p + 1'b1;
          state <= (NW'(p + 1'b1) == n) ? S_IDLE : S_CP_RD;
        end
        S_WAIT: if (stat.done) state <= ret;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- design/nbf_dp.sv -----
`timescale 1ns / 1ps
module nbf_dp import nbf_pkg::*; #(
  parameter int MAX_PARTICLES = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  dp_cmd_t            cmd,
  output dp_stat_t           stat,
  input  cfg_t               cfg,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic signed [31:0] in_pos_z,
  input  logic signed [31:0] in_vel_x,
  input  logic signed [31:0] in_vel_y,
  input  logic signed [31:0] in_vel_z,
  input  logic [31:0]        in_mass,
  nbf_out_if.source          out_ch
);

  localparam int AW = $clog2(MAX_PARTICLES);

  logic [31:0] px_mem [MAX_PARTICLES];
  logic [31:0] py_mem [MAX_PARTICLES];
  logic [31:0] pz_mem [MAX_PARTICLES];
  logic [31:0] vx_mem [MAX_PARTICLES];
  logic [31:0] vy_mem [MAX_PARTICLES];
  logic [31:0] vz_mem [MAX_PARTICLES];
  logic [31:0] m_mem  [MAX_PARTICLES];
  logic [31:0] npx_mem [MAX_PARTICLES];
  logic [31:0] npy_mem [MAX_PARTICLES];
  logic [31:0] npz_mem [MAX_PARTICLES];
  logic [31:0] nvx_mem [MAX_PARTICLES];
  logic [31:0] nvy_mem [MAX_PARTICLES];
  logic [31:0] nvz_mem [MAX_PARTICLES];

  logic [31:0] rd_px, rd_py, rd_pz, rd_vx, rd_vy, rd_vz, rd_m;
  logic [31:0] rd_npx, rd_npy, rd_npz, rd_nvx, rd_nvy, rd_nvz;

  logic [AW-1:0] a;
  logic [AW-1:0] load_ptr;

  logic signed [31:0] pi [3];
  logic signed [31:0] vi [3];
  logic signed [31:0] np [3];
  logic signed [31:0] nv [3];
  logic signed [47:0] acc [3];
  logic [32:0]        ud [3];
  logic               dneg [3];
  logic [31:0]        mi, mp, gm;
  logic [63:0]        d2, den, num, fac;
  logic [47:0]        vfac;
  dp_op_t             pend_op;
  logic [1:0]         pend_axis;

  logic [63:0] sq_v, sq_res, sq_bit;
  logic [4:0]  sq_cnt;
  logic        sq_busy, sq_done;

  logic               mul_start, mul_done;
  logic [63:0]        mul_a, mul_b;
  logic [127:0]       prod;
  logic               div_start, div_done;
  logic [63:0]        div_n, div_d, quot;

  logic [47:0]        con_c;
  logic [33:0]        step_c;
  logic signed [49:0] acc_sum;
  logic signed [35:0] np_sum, nv_sum;
  logic [30:0]        lim;
  logic signed [32:0] diff [3];
  logic [31:0]        rd_pos [3];

  logic               out_valid;
  logic [IDX_W-1:0]   out_idx;
  logic signed [31:0] out_p [3];
  logic signed [31:0] out_v [3];
  logic               out_last;

  function automatic logic [31:0] abs32(input logic signed [31:0] v);
    return v[31] ? ~$unsigned(v) + 32'd1 : $unsigned(v);
  endfunction

  function automatic logic [47:0] abs48(input logic signed [47:0] v);
    return v[47] ? ~$unsigned(v) + 48'd1 : $unsigned(v);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    if (v > 36'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -36'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [47:0] sat48(input logic signed [49:0] v);
    if (v > 50'sh0_7FFF_FFFF_FFFF) return 48'sh7FFF_FFFF_FFFF;
    if (v < -50'sh0_8000_0000_0000) return 48'sh8000_0000_0000;
    return v[47:0];
  endfunction

  function automatic logic signed [31:0] reflect(input logic signed [31:0] p,
                                                 input logic signed [31:0] v,
                                                 input logic [30:0] lm);
    if (p >= $signed({1'b0, lm})) return v[31] ? v : -v;
    if (p <= 32'sd0) return v[31] ? ((v == 32'sh80000000) ? 32'sh7FFFFFFF : -v) : v;
    return v;
  endfunction

  assign a = cmd.addr[AW-1:0];

  assign rd_pos[0] = rd_px;
  assign rd_pos[1] = rd_py;
  assign rd_pos[2] = rd_pz;
  for (genvar g = 0; g < 3; g++) begin : g_diff
    assign diff[g] = {rd_pos[g][31], rd_pos[g]} - {pi[g][31], pi[g]};
  end

  always_comb begin
    mul_start = 1'b0;
    div_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    div_n     = '0;
    div_d     = '0;
    case (cmd.op)
      OP_SQ: begin
        mul_start = 1'b1;
        mul_a     = {31'b0, ud[cmd.axis]};
        mul_b     = {31'b0, ud[cmd.axis]};
      end
      OP_CUBE: begin
        mul_start = 1'b1;
        mul_a     = d2;
        mul_b     = sq_res;
      end
      OP_GM: begin
        mul_start = 1'b1;
        mul_a     = {32'b0, cfg.grav};
        mul_b     = {32'b0, mi};
      end
      OP_NUM: begin
        mul_start = 1'b1;
        mul_a     = {32'b0, gm};
        mul_b     = {32'b0, mp};
      end
      OP_CON: begin
        mul_start = 1'b1;
        mul_a     = {31'b0, ud[cmd.axis]};
        mul_b     = fac;
      end
      OP_DP: begin
        mul_start = 1'b1;
        mul_a     = {32'b0, abs32(vi[cmd.axis])};
        mul_b     = {32'b0, cfg.dt};
      end
      OP_DV: begin
        mul_start = 1'b1;
        mul_a     = {16'b0, abs48(acc[cmd.axis])};
        mul_b     = {16'b0, vfac};
      end
      OP_DIV: begin
        div_start = 1'b1;
        div_n     = num;
        div_d     = den;
      end
      OP_VFAC: begin
        div_start = 1'b1;
        div_n     = {16'b0, cfg.dt, 16'b0};
        div_d     = {32'b0, mi};
      end
      default: ;
    endcase
  end

  nbf_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (prod)
  );

  nbf_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_n),
    .den   (div_d),
    .done  (div_done),
    .quot  (quot)
  );

  // capped shifted products
  assign con_c  = (|prod[127:64] || prod[63:16] > 48'h8000_0000_0000) ?
                  48'h8000_0000_0000 : prod[63:16];
  assign step_c = (|prod[127:50] || prod[49:16] > 34'h2_0000_0000) ?
                  34'h2_0000_0000 : prod[49:16];

  always_comb begin
    case (pend_axis)
      2'd0:    lim = cfg.xlim;
      2'd1:    lim = cfg.ylim;
      default: lim = cfg.zlim;
    endcase
  end

  assign acc_sum = dneg[pend_axis] ? 50'(acc[pend_axis]) - $signed({2'b0, con_c})
                                   : 50'(acc[pend_axis]) + $signed({2'b0, con_c});
  assign np_sum  = vi[pend_axis][31] ? 36'(pi[pend_axis]) - $signed({2'b0, step_c})
                                     : 36'(pi[pend_axis]) + $signed({2'b0, step_c});
  assign nv_sum  = acc[pend_axis][47] ? 36'(vi[pend_axis]) - $signed({2'b0, step_c})
                                      : 36'(vi[pend_axis]) + $signed({2'b0, step_c});

  assign stat.done     = mul_done | div_done | sq_done;
  assign stat.out_free = !out_valid || out_ch.ready;

  // particle stores
  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD) begin
      px_mem[load_ptr] <= in_pos_x;
      py_mem[load_ptr] <= in_pos_y;
      pz_mem[load_ptr] <= in_pos_z;
      vx_mem[load_ptr] <= in_vel_x;
      vy_mem[load_ptr] <= in_vel_y;
      vz_mem[load_ptr] <= in_vel_z;
      m_mem[load_ptr]  <= in_mass;
    end else if (cmd.op == OP_CP_WR) begin
      px_mem[a] <= rd_npx;
      py_mem[a] <= rd_npy;
      pz_mem[a] <= rd_npz;
      vx_mem[a] <= rd_nvx;
      vy_mem[a] <= rd_nvy;
      vz_mem[a] <= rd_nvz;
    end
    rd_px <= px_mem[a];
    rd_py <= py_mem[a];
    rd_pz <= pz_mem[a];
    rd_vx <= vx_mem[a];
    rd_vy <= vy_mem[a];
    rd_vz <= vz_mem[a];
    rd_m  <= m_mem[a];
  end

  // updated particles, held until the step ends
  always_ff @(posedge clk) begin
    if (cmd.op == OP_EMIT) begin
      npx_mem[a] <= np[0];
      npy_mem[a] <= np[1];
      npz_mem[a] <= np[2];
      nvx_mem[a] <= nv[0];
      nvy_mem[a] <= nv[1];
      nvz_mem[a] <= nv[2];
    end
    rd_npx <= npx_mem[a];
    rd_npy <= npy_mem[a];
    rd_npz <= npz_mem[a];
    rd_nvx <= nvx_mem[a];
    rd_nvy <= nvy_mem[a];
    rd_nvz <= nvz_mem[a];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int g = 0; g < 3; g++) acc[g] <= '0;
      pend_op   <= OP_NONE;
      pend_axis <= '0;
      load_ptr  <= '0;
      out_valid <= 1'b0;
      sq_busy   <= 1'b0;
      sq_done   <= 1'b0;
      sq_cnt    <= '0;
    end else begin
      sq_done <= 1'b0;
      if (mul_start || div_start) begin
        pend_op   <= cmd.op;
        pend_axis <= cmd.axis;
      end

      if (cmd.op == OP_LOAD) begin
        load_ptr <= (load_ptr == AW'(MAX_PARTICLES - 1)) ? '0 : load_ptr + 1'b1;
      end

      if (cmd.op == OP_CAP_I) begin
        pi[0] <= rd_px;
        pi[1] <= rd_py;
        pi[2] <= rd_pz;
        vi[0] <= rd_vx;
        vi[1] <= rd_vy;
        vi[2] <= rd_vz;
        mi    <= rd_m;
        for (int g = 0; g < 3; g++) acc[g] <= '0;
      end

      if (cmd.op == OP_CAP_P) begin
        for (int g = 0; g < 3; g++) begin
          dneg[g] <= diff[g][32];
          ud[g]   <= diff[g][32] ? ~$unsigned(diff[g]) + 33'd1 : $unsigned(diff[g]);
        end
        mp <= rd_m;
        d2 <= '0;
      end

      // integer square root, two bits per cycle
      if (cmd.op == OP_SQRT) begin
        sq_v    <= d2 << 14;
        sq_res  <= '0;
        sq_bit  <= 64'h4000_0000_0000_0000;
        sq_cnt  <= '0;
        sq_busy <= 1'b1;
      end else if (sq_busy) begin
        if (sq_v >= sq_res + sq_bit) begin
          sq_v   <= sq_v - (sq_res + sq_bit);
          sq_res <= (sq_res >> 1) + sq_bit;
        end else begin
          sq_res <= sq_res >> 1;
        end
        sq_bit <= sq_bit >> 2;
        sq_cnt <= sq_cnt + 5'd1;
        if (&sq_cnt) begin
          sq_busy <= 1'b0;
          sq_done <= 1'b1;
        end
      end

      if (mul_done) begin
        case (pend_op)
          OP_SQ:   d2 <= d2 + 64'(prod[64:16]);
          OP_CUBE: begin
            if (|prod[127:78]) den <= 64'h7FFF_FFFF_FFFF_FFFF + {32'b0, cfg.eps};
            else               den <= {1'b0, prod[77:15]} + {32'b0, cfg.eps};
          end
          OP_GM:   gm <= prod[63:32];
          OP_NUM:  num <= prod[63:0];
          OP_CON:  acc[pend_axis] <= sat48(acc_sum);
          OP_DP:   np[pend_axis] <= sat32(np_sum);
          OP_DV:   nv[pend_axis] <= reflect(np[pend_axis], sat32(nv_sum), lim);
          default: ;
        endcase
      end

      if (div_done) begin
        case (pend_op)
          OP_DIV:  fac <= quot;
          OP_VFAC: vfac <= (mi == '0) ? 48'hFFFF_FFFF_FFFF : quot[47:0];
          default: ;
        endcase
      end

      if (cmd.op == OP_EMIT) begin
        out_valid <= 1'b1;
        out_idx   <= cmd.addr;
        out_last  <= cmd.last;
        for (int g = 0; g < 3; g++) begin
          out_p[g] <= np[g];
          out_v[g] <= nv[g];
        end
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign out_ch.valid          = out_valid;
  assign out_ch.particle_index = out_idx;
  assign out_ch.out_pos_x      = out_p[0];
  assign out_ch.out_pos_y      = out_p[1];
  assign out_ch.out_pos_z      = out_p[2];
  assign out_ch.out_vel_x      = out_v[0];
  assign out_ch.out_vel_y      = out_v[1];
  assign out_ch.out_vel_z      = out_v[2];
  assign out_ch.last_particle  = out_last;

endmodule

// ----- design/nbody_direct_force_step.sv -----
`timescale 1ns / 1ps
// Direct-sum gravity with one Euler step per step command.
// in_ch: cmd 0 loads one particle at the load pointer (wraps at MAX_PARTICLES),
//   cmd 1 runs a step over the first min(particle_count, MAX_PARTICLES) particles.
// out_ch: one item per particle in index order, last_particle on the final one.
// cfg_ch: register writes, always ready; write only while no step is running.
// A step works through every ordered pair of particles using the shared 64-bit
// divider, the square root and a multiplier built from four 32x32 partial
// products, then updates each particle and ends with a write-back pass that
// copies the updated particles into the particle stores.
// in_ch is ready only while no step is running.
// First result appears after the first particle's force sum.
// A stalled out_ch holds the finished particle in the output register, and the
// step waits before emitting the next particle until it is taken.
// Reset clears the controller, load pointer, output valid and registers to
// their defaults; particle stores are undefined until loaded.
module nbody_direct_force_step import nbf_pkg::*; #(
  parameter int MAX_PARTICLES = 64
) (
  input  logic       clk,
  input  logic       rst,
  nbf_in_if.sink     in_ch,
  nbf_out_if.source  out_ch,
  nbf_cfg_if.sink    cfg_ch
);

  cfg_t     cfg;
  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.count <= 7'd64;
      cfg.grav  <= 32'd0;
      cfg.eps   <= 32'd1;
      cfg.dt    <= 32'd65536;
      cfg.xlim  <= 31'h7FFF_FFFF;
      cfg.ylim  <= 31'h7FFF_FFFF;
      cfg.zlim  <= 31'h7FFF_FFFF;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_COUNT: cfg.count <= cfg_ch.data[6:0];
        REG_GRAV:  cfg.grav  <= cfg_ch.data;
        REG_SOFT:  cfg.eps   <= cfg_ch.data;
        REG_DT:    cfg.dt    <= cfg_ch.data;
        REG_XLIM:  cfg.xlim  <= cfg_ch.data[30:0];
        REG_YLIM:  cfg.ylim  <= cfg_ch.data[30:0];
        REG_ZLIM:  cfg.zlim  <= cfg_ch.data[30:0];
        default: ;
      endcase
    end
  end

  nbf_ctrl #(.MAX_PARTICLES(MAX_PARTICLES)) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_cmd   (in_ch.cmd),
    .in_ready (in_ch.ready),
    .count    (cfg.count),
    .stat     (stat),
    .cmd      (cmd)
  );

  nbf_dp #(.MAX_PARTICLES(MAX_PARTICLES)) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .cfg      (cfg),
    .in_pos_x (in_ch.in_pos_x),
    .in_pos_y (in_ch.in_pos_y),
    .in_pos_z (in_ch.in_pos_z),
    .in_vel_x (in_ch.in_vel_x),
    .in_vel_y (in_ch.in_vel_y),
    .in_vel_z (in_ch.in_vel_z),
    .in_mass  (in_ch.in_mass),
    .out_ch   (out_ch)
  );

endmodule
